FILE: src/framebuffer_config_best_match_defines.svh
// assertion macros for the framebuffer config best match block
`ifndef FRAMEBUFFER_CONFIG_BEST_MATCH_DEFINES_SVH
`define FRAMEBUFFER_CONFIG_BEST_MATCH_DEFINES_SVH

// same-cycle property, disabled while in reset
`define FBCBM_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
    else $error(msg);

// antecedent this cycle, consequent on the next edge
`define FBCBM_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fbcbm_pkg.sv
// shared types, constants and helpers for the framebuffer config best match block
package fbcbm_pkg;

  localparam int MAX_CANDIDATES_DEF = 64;
  localparam int QUEUE_DEPTH        = 2;
  localparam int Q_PTR_W            = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W            = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic [5:0]  index_t;
  typedef logic [2:0]  missing_t;
  typedef logic [17:0] color_cost_t;
  typedef logic [20:0] extra_cost_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WANTED_COLOR   = 3'd0,
    REG_WANTED_ALPHA   = 3'd1,
    REG_WANTED_DEPTH   = 3'd2,
    REG_WANTED_STENCIL = 3'd3,
    REG_WANTED_SAMPLES = 3'd4,
    REG_WANTED_VERSION = 3'd5,
    REG_WANTED_EXTRAS  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    missing_t    missing;
    color_cost_t color;
    extra_cost_t extra;
    logic        last;
  } score_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

  function automatic logic [19:0] sqdiff(input logic [9:0] want, input logic [9:0] have);
    logic [9:0] d;
    d = (want > have) ? (want - have) : (have - want);
    return (want != 10'd0) ? (d * d) : 20'd0;
  endfunction

endpackage

FILE: src/fbcbm_front.sv
// front end: config registers, word acceptance and candidate scoring
module fbcbm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wen,
  input  logic [fbcbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbcbm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fbcbm_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  input  fbcbm_pkg::q_status_t                q_stat,
  output logic                                push,
  output fbcbm_pkg::score_t                   push_entry
);

  logic [23:0] wanted_color_r;
  logic [7:0]  wanted_alpha_r;
  logic [7:0]  wanted_depth_r;
  logic [7:0]  wanted_stencil_r;
  logic [7:0]  wanted_samples_r;
  logic [9:0]  wanted_version_r;
  logic [1:0]  wanted_extras_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_color_r   <= '0;
      wanted_alpha_r   <= '0;
      wanted_depth_r   <= '0;
      wanted_stencil_r <= '0;
      wanted_samples_r <= '0;
      wanted_version_r <= '0;
      wanted_extras_r  <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        fbcbm_pkg::REG_WANTED_COLOR:   wanted_color_r   <= cfg_wdata[23:0];
        fbcbm_pkg::REG_WANTED_ALPHA:   wanted_alpha_r   <= cfg_wdata[7:0];
        fbcbm_pkg::REG_WANTED_DEPTH:   wanted_depth_r   <= cfg_wdata[7:0];
        fbcbm_pkg::REG_WANTED_STENCIL: wanted_stencil_r <= cfg_wdata[7:0];
        fbcbm_pkg::REG_WANTED_SAMPLES: wanted_samples_r <= cfg_wdata[7:0];
        fbcbm_pkg::REG_WANTED_VERSION: wanted_version_r <= cfg_wdata[9:0];
        fbcbm_pkg::REG_WANTED_EXTRAS:  wanted_extras_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic [7:0] red, green, blue, alpha, depth, stencil, samples;
  logic [9:0] version;
  logic       fbuf, noerr;

  assign red     = in_tdata[7:0];
  assign green   = in_tdata[15:8];
  assign blue    = in_tdata[23:16];
  assign alpha   = in_tdata[31:24];
  assign depth   = in_tdata[39:32];
  assign stencil = in_tdata[47:40];
  assign samples = in_tdata[55:48];
  assign version = in_tdata[65:56];
  assign fbuf    = in_tdata[66];
  assign noerr   = in_tdata[67];

  logic [5:0] miss_bits;
  logic [19:0] sq_r, sq_g, sq_b, sq_a, sq_d, sq_s, sq_m, sq_v;

  always_comb begin
    miss_bits[0] = (wanted_alpha_r   != 8'd0) && (alpha   == 8'd0);
    miss_bits[1] = (wanted_depth_r   != 8'd0) && (depth   == 8'd0);
    miss_bits[2] = (wanted_stencil_r != 8'd0) && (stencil == 8'd0);
    miss_bits[3] = (wanted_samples_r != 8'd0) && (samples == 8'd0);
    miss_bits[4] = wanted_extras_r[0] && !fbuf;
    miss_bits[5] = wanted_extras_r[1] && !noerr;

    sq_r = fbcbm_pkg::sqdiff({2'b00, wanted_color_r[7:0]},   {2'b00, red});
    sq_g = fbcbm_pkg::sqdiff({2'b00, wanted_color_r[15:8]},  {2'b00, green});
    sq_b = fbcbm_pkg::sqdiff({2'b00, wanted_color_r[23:16]}, {2'b00, blue});
    sq_a = fbcbm_pkg::sqdiff({2'b00, wanted_alpha_r},   {2'b00, alpha});
    sq_d = fbcbm_pkg::sqdiff({2'b00, wanted_depth_r},   {2'b00, depth});
    sq_s = fbcbm_pkg::sqdiff({2'b00, wanted_stencil_r}, {2'b00, stencil});
    sq_m = fbcbm_pkg::sqdiff({2'b00, wanted_samples_r}, {2'b00, samples});
    sq_v = fbcbm_pkg::sqdiff(wanted_version_r, version);

    push_entry.missing = 3'(miss_bits[0]) + 3'(miss_bits[1]) + 3'(miss_bits[2])
                       + 3'(miss_bits[3]) + 3'(miss_bits[4]) + 3'(miss_bits[5]);
    push_entry.color   = 18'(sq_r[15:0]) + 18'(sq_g[15:0]) + 18'(sq_b[15:0]);
    push_entry.extra   = 21'(sq_a[15:0]) + 21'(sq_d[15:0]) + 21'(sq_s[15:0])
                       + 21'(sq_m[15:0]) + 21'(sq_v);
    push_entry.last    = in_tlast;
  end

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;

endmodule

FILE: src/fbcbm_queue.sv
// short queue of scored words between the front and back ends
module fbcbm_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fbcbm_pkg::score_t     push_entry,
  input  logic                  pop,
  output fbcbm_pkg::score_t     head,
  output fbcbm_pkg::q_status_t  q_stat
);

  localparam int DEPTH = fbcbm_pkg::QUEUE_DEPTH;
  localparam int PW    = fbcbm_pkg::Q_PTR_W;
  localparam int CW    = fbcbm_pkg::Q_CNT_W;

  fbcbm_pkg::score_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.count = count_r;

endmodule

FILE: src/fbcbm_back.sv
// back end: running best candidate and result output register
module fbcbm_back #(
  parameter int MAX_CANDIDATES = fbcbm_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fbcbm_pkg::score_t                 head,
  input  fbcbm_pkg::q_status_t              q_stat,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fbcbm_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int IDX_W = $clog2(MAX_CANDIDATES);

  logic [CNT_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        win_r;
  logic                    have_r;
  fbcbm_pkg::missing_t     miss_r;
  fbcbm_pkg::color_cost_t  color_r;
  fbcbm_pkg::extra_cost_t  extra_r;

  logic                                out_valid_r, out_valid_nxt;
  logic [fbcbm_pkg::OUT_DATA_W-1:0]    out_data_r;

  logic                    scoring, take;
  logic [IDX_W-1:0]        upd_win;
  fbcbm_pkg::missing_t     upd_miss;
  fbcbm_pkg::color_cost_t  upd_color;
  fbcbm_pkg::extra_cost_t  upd_extra;

  assign pop = !q_stat.empty && (!head.last || !out_valid_r || out_tready);
  assign scoring = (cnt_r < CNT_W'(MAX_CANDIDATES));

  always_comb begin
    priority if (!have_r || head.missing < miss_r) begin
      take = 1'b1;
    end else if (head.missing == miss_r) begin
      take = (head.color < color_r) || ((head.color == color_r) && (head.extra < extra_r));
    end else begin
      take = 1'b0;
    end
    if (scoring && take) begin
      upd_win   = cnt_r[IDX_W-1:0];
      upd_miss  = head.missing;
      upd_color = head.color;
      upd_extra = head.extra;
    end else begin
      upd_win   = win_r;
      upd_miss  = miss_r;
      upd_color = color_r;
      upd_extra = extra_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      win_r   <= '0;
      have_r  <= 1'b0;
      miss_r  <= '1;
      color_r <= '1;
      extra_r <= '1;
    end else if (pop) begin
      if (head.last) begin
        cnt_r   <= '0;
        win_r   <= '0;
        have_r  <= 1'b0;
        miss_r  <= '1;
        color_r <= '1;
        extra_r <= '1;
      end else begin
        if (scoring) begin
          cnt_r <= cnt_r + 1'b1;
        end
        win_r   <= upd_win;
        have_r  <= have_r || scoring;
        miss_r  <= upd_miss;
        color_r <= upd_color;
        extra_r <= upd_extra;
      end
    end
  end

  always_comb begin
    if (pop && head.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_data_r <= {upd_extra, upd_color, upd_miss, fbcbm_pkg::index_t'(upd_win)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: src/framebuffer_config_best_match.sv
// top level of the framebuffer config best match block
// usage:
//   cfg_wen/cfg_index/cfg_wdata set the wanted configuration, one register per
//   write, only while the block is idle.
//   candidates stream in on in_*, one word per cycle while in_tready is high,
//   in_tlast on the last one of a set. each word is scored as it is taken and
//   parked in a two-word queue. the back end folds each queued score into the
//   running best at one word per cycle unless a held result stalls a last
//   word; on the last word it loads the winner into the output register.
//   out_tvalid rises at the edge that takes the back end's last word.
//   throughput is one candidate per cycle, set by the combinational compare in
//   the back end; a held result stalls only the next last word, and the queue
//   then fills and in_tready drops.
//   candidates past MAX_CANDIDATES in a set are not scored; their last still
//   closes the set.
//   reset clears the wanted registers to zero, empties the queue, drops the
//   running best and any pending result.
`include "framebuffer_config_best_match_defines.svh"

module framebuffer_config_best_match #(
  parameter int MAX_CANDIDATES = fbcbm_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wen,
  input  logic [fbcbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbcbm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // red 7:0, green 15:8, blue 23:16, alpha 31:24, depth 39:32, stencil 47:40,
  // samples 55:48, version 65:56, float buffer 66, no-error 67, zero 71:68
  input  logic [fbcbm_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // best index 5:0, missing 8:6, colour cost 26:9, extra cost 47:27
  output logic [fbcbm_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic                  push, pop;
  fbcbm_pkg::score_t     push_entry, head;
  fbcbm_pkg::q_status_t  q_stat;

  fbcbm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  fbcbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  fbcbm_back #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `FBCBM_ASSERT(a_no_pop_empty, clk, rst_n, !pop || !q_stat.empty, "pop from empty queue")
  `FBCBM_ASSERT_NEXT(a_accept_queued, clk, rst_n, in_tvalid && in_tready, q_stat.count != '0, "accepted word not queued")
  `FBCBM_ASSERT(a_result_from_last, clk, rst_n, !$rose(out_tvalid) || $past(pop && head.last), "result without last word")
  `FBCBM_ASSERT_NEXT(a_full_stalls, clk, rst_n, q_stat.full && !pop, !in_tready, "queue full but input ready")

endmodule

FILE: verif/framebuffer_config_best_match_checker.sv
// scoring model and result comparison for the framebuffer config best match block
module framebuffer_config_best_match_checker #(
  parameter int MAX_CANDS = fbcbm_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wen,
  input  logic [fbcbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbcbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [fbcbm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [fbcbm_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                               fail_count,
  output int                               pending,
  output int                               winners_checked
);

  typedef struct packed {
    fbcbm_pkg::index_t      idx;
    fbcbm_pkg::missing_t    missing;
    fbcbm_pkg::color_cost_t color;
    fbcbm_pkg::extra_cost_t extra;
  } winner_t;

  winner_t winner_q[$];

  logic [23:0] want_color;
  logic [7:0]  want_alpha;
  logic [7:0]  want_depth;
  logic [7:0]  want_stencil;
  logic [7:0]  want_samples;
  logic [9:0]  want_version;
  logic [1:0]  want_extras;

  int unsigned            set_pos;
  fbcbm_pkg::missing_t    run_missing;
  fbcbm_pkg::color_cost_t run_color;
  fbcbm_pkg::extra_cost_t run_extra;
  fbcbm_pkg::index_t      run_idx;
  logic                   run_valid;

  function automatic int unsigned sq_gap(int unsigned want, int unsigned have);
    int unsigned d;
    d = (want > have) ? want - have : have - want;
    return (want != 0) ? d * d : 0;
  endfunction

  task automatic clear_running();
    set_pos     = 0;
    run_missing = '1;
    run_color   = '1;
    run_extra   = '1;
    run_idx     = '0;
    run_valid   = 1'b0;
  endtask

  task automatic score_candidate(input logic [fbcbm_pkg::IN_DATA_W-1:0] d, input logic is_end);
    logic [7:0]  r, g, b, a, dp, s, n;
    logic [9:0]  v;
    logic        fb, ne;
    int unsigned miss, col, ext;
    logic        take;
    winner_t     w;
    r  = d[7:0];
    g  = d[15:8];
    b  = d[23:16];
    a  = d[31:24];
    dp = d[39:32];
    s  = d[47:40];
    n  = d[55:48];
    v  = d[65:56];
    fb = d[66];
    ne = d[67];
    if (set_pos < MAX_CANDS) begin
      miss = 0;
      if (want_alpha != 0 && a == 0) miss++;
      if (want_depth != 0 && dp == 0) miss++;
      if (want_stencil != 0 && s == 0) miss++;
      if (want_samples != 0 && n == 0) miss++;
      if (want_extras[0] && !fb) miss++;
      if (want_extras[1] && !ne) miss++;
      col = sq_gap(want_color[7:0], r) + sq_gap(want_color[15:8], g)
          + sq_gap(want_color[23:16], b);
      ext = sq_gap(want_alpha, a) + sq_gap(want_depth, dp) + sq_gap(want_stencil, s)
          + sq_gap(want_samples, n) + sq_gap(want_version, v);
      if (!run_valid || miss < run_missing) take = 1'b1;
      else if (miss == run_missing) take = (col < run_color) ||
                                           (col == run_color && ext < run_extra);
      else take = 1'b0;
      if (take) begin
        run_missing = miss[2:0];
        run_color   = col[17:0];
        run_extra   = ext[20:0];
        run_idx     = set_pos[5:0];
        run_valid   = 1'b1;
      end
      set_pos++;
    end
    if (is_end) begin
      w.idx     = run_idx;
      w.missing = run_missing;
      w.color   = run_color;
      w.extra   = run_extra;
      winner_q.push_back(w);
      clear_running();
    end
  endtask

  task automatic check_winner(input logic [fbcbm_pkg::OUT_DATA_W-1:0] d);
    winner_t w;
    if (winner_q.size() == 0) begin
      $error("result word with no candidate set closed: %h", d);
      fail_count++;
    end else begin
      w = winner_q.pop_front();
      winners_checked++;
      if (d[5:0] !== w.idx) begin
        $error("best_index: expected %0d, actual %0d", w.idx, d[5:0]);
        fail_count++;
      end
      if (d[8:6] !== w.missing) begin
        $error("best_missing: expected %0d, actual %0d", w.missing, d[8:6]);
        fail_count++;
      end
      if (d[26:9] !== w.color) begin
        $error("best_color_cost: expected %0d, actual %0d", w.color, d[26:9]);
        fail_count++;
      end
      if (d[47:27] !== w.extra) begin
        $error("best_extra_cost: expected %0d, actual %0d", w.extra, d[47:27]);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      want_color   = '0;
      want_alpha   = '0;
      want_depth   = '0;
      want_stencil = '0;
      want_samples = '0;
      want_version = '0;
      want_extras  = '0;
      clear_running();
      winner_q.delete();
    end else begin
      if (cfg_wen) begin
        case (fbcbm_pkg::cfg_reg_t'(cfg_index))
          fbcbm_pkg::REG_WANTED_COLOR:   want_color   = cfg_wdata[23:0];
          fbcbm_pkg::REG_WANTED_ALPHA:   want_alpha   = cfg_wdata[7:0];
          fbcbm_pkg::REG_WANTED_DEPTH:   want_depth   = cfg_wdata[7:0];
          fbcbm_pkg::REG_WANTED_STENCIL: want_stencil = cfg_wdata[7:0];
          fbcbm_pkg::REG_WANTED_SAMPLES: want_samples = cfg_wdata[7:0];
          fbcbm_pkg::REG_WANTED_VERSION: want_version = cfg_wdata[9:0];
          fbcbm_pkg::REG_WANTED_EXTRAS:  want_extras  = cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_winner(out_tdata);
      if (in_tvalid && in_tready) score_candidate(in_tdata, in_tlast);
    end
    pending = winner_q.size();
  end

endmodule

FILE: verif/framebuffer_config_best_match_test.sv
// stimulus and verdict for the framebuffer config best match block
module framebuffer_config_best_match_test;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] depth;
    logic [7:0] stencil;
    logic [7:0] samples;
    logic [9:0] version;
    logic       fbuf;
    logic       noerr;
  } cand_t;

  typedef struct packed {
    logic [23:0] color;
    logic [7:0]  alpha;
    logic [7:0]  depth;
    logic [7:0]  stencil;
    logic [7:0]  samples;
    logic [9:0]  version;
    logic [1:0]  extras;
  } wanted_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             cfg_wen    = 1'b0;
  logic [fbcbm_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [fbcbm_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [fbcbm_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                             in_tlast   = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [fbcbm_pkg::OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int winners_checked;

  logic    quiet = 1'b0;
  int      stall_left = 0;
  int      sent = 0;
  int      sets = 0;
  int      settings = 0;
  wanted_t cur_want = '0;

  framebuffer_config_best_match dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  framebuffer_config_best_match_checker match_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .winners_checked (winners_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (quiet) begin
      out_tready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  initial begin
    #5000000;
    $display("framebuffer_config_best_match_test NOT OK");
    $finish;
  end

  function automatic cand_t mk_cand(int r, int g, int b, int a, int d, int s, int n,
                                    int v, int f, int e);
    cand_t c;
    c.red     = r[7:0];
    c.green   = g[7:0];
    c.blue    = b[7:0];
    c.alpha   = a[7:0];
    c.depth   = d[7:0];
    c.stencil = s[7:0];
    c.samples = n[7:0];
    c.version = v[9:0];
    c.fbuf    = f[0];
    c.noerr   = e[0];
    return c;
  endfunction

  function automatic wanted_t mk_want(int col, int a, int d, int s, int n, int v, int x);
    wanted_t w;
    w.color   = col[23:0];
    w.alpha   = a[7:0];
    w.depth   = d[7:0];
    w.stencil = s[7:0];
    w.samples = n[7:0];
    w.version = v[9:0];
    w.extras  = x[1:0];
    return w;
  endfunction

  // zero, top, close to the wanted value or anywhere
  function automatic int pick_val(int want, int top);
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = top;
      2, 3: begin
        v = $urandom_range(0, 1) ? want + $urandom_range(0, 6) : want - $urandom_range(0, 6);
        if (v < 0) v = 0;
        if (v > top) v = top;
      end
      default: v = $urandom_range(0, top);
    endcase
    return v;
  endfunction

  function automatic cand_t rand_cand();
    return mk_cand(pick_val(cur_want.color[7:0], 255), pick_val(cur_want.color[15:8], 255),
                   pick_val(cur_want.color[23:16], 255), pick_val(cur_want.alpha, 255),
                   pick_val(cur_want.depth, 255), pick_val(cur_want.stencil, 255),
                   pick_val(cur_want.samples, 255), pick_val(cur_want.version, 1023),
                   $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  function automatic int rand_field(int top);
    int v;
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = top;
      default: v = $urandom_range(1, top);
    endcase
    return v;
  endfunction

  function automatic wanted_t rand_wanted();
    wanted_t w;
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = mk_want(24'hFFFFFF, 255, 255, 255, 255, 1023, 3);
      default: w = mk_want({8'(rand_field(255)), 8'(rand_field(255)), 8'(rand_field(255))},
                           rand_field(255), rand_field(255), rand_field(255),
                           rand_field(255), rand_field(1023), $urandom_range(0, 3));
    endcase
    return w;
  endfunction

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic put_reg(fbcbm_pkg::cfg_reg_t r, logic [fbcbm_pkg::CFG_DATA_W-1:0] v);
    cfg_wen   = 1'b1;
    cfg_index = r;
    cfg_wdata = v;
    @(negedge clk);
  endtask

  task automatic apply_wanted(wanted_t w);
    drain();
    put_reg(fbcbm_pkg::REG_WANTED_COLOR, w.color);
    put_reg(fbcbm_pkg::REG_WANTED_ALPHA, {16'd0, w.alpha});
    put_reg(fbcbm_pkg::REG_WANTED_DEPTH, {16'd0, w.depth});
    put_reg(fbcbm_pkg::REG_WANTED_STENCIL, {16'd0, w.stencil});
    put_reg(fbcbm_pkg::REG_WANTED_SAMPLES, {16'd0, w.samples});
    put_reg(fbcbm_pkg::REG_WANTED_VERSION, {14'd0, w.version});
    put_reg(fbcbm_pkg::REG_WANTED_EXTRAS, {22'd0, w.extras});
    cfg_wen  = 1'b0;
    cur_want = w;
    settings++;
  endtask

  task automatic send_cand(cand_t c, logic is_end);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'd0, c.noerr, c.fbuf, c.version, c.samples, c.stencil, c.depth,
                 c.alpha, c.blue, c.green, c.red};
    in_tlast  = is_end;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
    if (is_end) sets++;
  endtask

  initial begin
    int    rnd_items;
    int    size;
    int    sets_here;
    cand_t c;
    cand_t prev;
    rnd_items = 0;
    sets_here = 0;
    prev      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: nothing wanted, every score zero
    send_cand(mk_cand(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
    repeat (2) send_cand(mk_cand(255, 255, 255, 255, 255, 255, 255, 1023, 1, 1), 1'b0);
    send_cand(mk_cand(255, 255, 255, 255, 255, 255, 255, 1023, 1, 1), 1'b1);

    // everything wanted at its top value; full tie keeps the earlier word
    apply_wanted(mk_want(24'hFFFFFF, 255, 255, 255, 255, 1023, 3));
    send_cand(mk_cand(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_cand(mk_cand(255, 255, 255, 255, 255, 255, 255, 1023, 1, 1), 1'b0);
    send_cand(mk_cand(255, 255, 255, 255, 255, 255, 255, 1023, 1, 1), 1'b1);
    send_cand(mk_cand(255, 255, 255, 0, 255, 255, 255, 1023, 1, 1), 1'b0);
    send_cand(mk_cand(255, 255, 255, 255, 255, 255, 255, 0, 1, 1), 1'b1);

    // partial wants: colour, then extra cost, decide among equal missing counts
    apply_wanted(mk_want(24'h0080FF, 8, 0, 4, 0, 0, 1));
    send_cand(mk_cand(200, 128, 7, 8, 0, 4, 0, 0, 1, 0), 1'b0);
    send_cand(mk_cand(250, 128, 7, 10, 0, 4, 0, 0, 1, 0), 1'b0);
    send_cand(mk_cand(250, 128, 7, 8, 0, 4, 0, 0, 1, 0), 1'b0);
    send_cand(mk_cand(255, 128, 0, 8, 9, 4, 3, 500, 0, 1), 1'b0);
    send_cand(mk_cand(250, 128, 7, 8, 0, 4, 0, 0, 1, 0), 1'b1);
    send_cand(mk_cand(0, 0, 0, 0, 0, 0, 0, 1023, 0, 0), 1'b1);

    apply_wanted(rand_wanted());
    while (rnd_items < 1900) begin
      if (sets_here >= 12) begin
        apply_wanted(rand_wanted());
        sets_here = 0;
      end
      case ($urandom_range(0, 39))
        0: size = $urandom_range(65, 80);
        1, 2, 3, 4: size = $urandom_range(9, 40);
        default: size = $urandom_range(1, 8);
      endcase
      for (int k = 0; k < size; k++) begin
        if (k > 0 && $urandom_range(0, 4) == 0) c = prev;
        else c = rand_cand();
        send_cand(c, k == size - 1);
        prev = c;
        rnd_items++;
      end
      sets_here++;
      quiet = (rnd_items > 1700);
    end

    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("covered %0d candidates in %0d sets under %0d wanted settings",
             sent, sets, settings);
    $display("%0d winners compared field by field", winners_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("framebuffer_config_best_match_test OK");
    end else begin
      $display("framebuffer_config_best_match_test NOT OK");
    end
    $finish;
  end

endmodule
